@@ design/assert_macros.svh @@
// Assertion helpers included by the receiver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define EFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/efr_pkg.sv @@
package efr_pkg;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_DLE = 8'h10;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] POS_MAX = 8'hFF;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_AWAIT   = 3'b001,
    PH_SIZE    = 3'b010,
    PH_CONTENT = 3'b100
  } phase_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] reply;
  } result_t;

endpackage

@@ design/efr_frame_fsm.sv @@
module efr_frame_fsm import efr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output result_t    result_o,
  output logic [1:0] held_count_o
);

  phase_e     phase_q, phase_d;
  logic       esc_q, esc_d;
  logic [7:0] len_q, len_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] xor_q, xor_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] held0_q, held0_d;
  logic [7:0] held1_q, held1_d;

  logic       keep;
  logic [7:0] pos_inc;

  assign pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + 8'd1;

  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    len_d    = len_q;
    pos_d    = pos_q;
    xor_d    = xor_q;
    cnt_d    = cnt_q;
    held0_d  = held0_q;
    held1_d  = held1_q;
    keep     = 1'b0;
    result_o = '{valid: 1'b0, kind: KIND_PAYLOAD, data: 8'h00, reply: 8'h00};

    if (phase_q != PH_SIZE && phase_q != PH_CONTENT) begin
      phase_d = PH_AWAIT;
      if (byte_i == CH_SOH) begin
        phase_d = PH_SIZE;
        esc_d   = 1'b0;
        len_d   = 8'h00;
        pos_d   = 8'h00;
        xor_d   = 8'h00;
        cnt_d   = 2'd0;
      end
    end else begin
      if (esc_q) begin
        esc_d = 1'b0;
        keep  = 1'b1;
      end else if (byte_i == CH_DLE) begin
        esc_d = 1'b1;
      end else if (phase_q == PH_CONTENT && pos_q == 8'd1 && byte_i == CH_EOT) begin
        phase_d        = PH_AWAIT;
        result_o.valid = 1'b1;
        result_o.data  = held0_q;
        if (xor_q == 8'h00) begin
          result_o.kind  = KIND_GOOD;
          result_o.reply = CH_ACK;
        end else begin
          result_o.kind  = KIND_BAD;
          result_o.reply = CH_NAK;
        end
      end else if (byte_i == CH_SOH || byte_i == CH_EOT) begin
        phase_d        = PH_AWAIT;
        result_o.valid = 1'b1;
        result_o.kind  = KIND_ABORT;
      end else begin
        keep = 1'b1;
      end

      if (keep) begin
        if (phase_q == PH_SIZE) begin
          phase_d = PH_CONTENT;
          len_d   = byte_i;
          pos_d   = 8'h00;
        end else begin
          pos_d = pos_inc;
          if (pos_inc == len_q) begin
            phase_d = PH_SIZE;
          end
        end
        xor_d = xor_q ^ byte_i;
        if (cnt_q >= 2'd2) begin
          result_o.valid = 1'b1;
          result_o.kind  = KIND_PAYLOAD;
          result_o.data  = held0_q;
          held0_d        = held1_q;
          held1_d        = byte_i;
          cnt_d          = 2'd2;
        end else begin
          if (cnt_q[0]) begin
            held1_d = byte_i;
          end else begin
            held0_d = byte_i;
          end
          cnt_d = cnt_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_AWAIT;
      esc_q   <= 1'b0;
      len_q   <= 8'h00;
      pos_q   <= 8'h00;
      xor_q   <= 8'h00;
      cnt_q   <= 2'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      xor_q   <= xor_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      held0_q <= held0_d;
      held1_q <= held1_d;
    end
  end

  assign held_count_o = cnt_q;

endmodule

@@ design/escaped_frame_receiver_xor_check_unit.sv @@
// Receiver for DLE-escaped, SOH-started packets with an XOR checksum.
// Raw line bytes enter on the slave stream, one per beat in s_axis_tdata.
// Results leave on the master stream: m_axis_tuser carries the kind
// (payload, packet good, checksum bad, framing abort), m_axis_tdata carries
// the payload byte or packet number in bits 7:0 and the reply byte
// (ACK, NAK or zero) in bits 15:8.
// A byte is registered on entry and decoded from the input register against
// the frame state; any result it causes lands in the output register.
// The block sustains one input beat per cycle as long as the master side
// takes its beats.
// Bytes that produce no result (noise, SOH, DLE, the first two kept bytes)
// never wait for the output side.
// Reset puts the framer in the wait-for-SOH state and empties both registers.
// When the receiver stalls with a result pending, the input register holds
// its byte only if that byte also produces a result, and s_axis_tready drops.
module escaped_frame_receiver_xor_check_unit import efr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [15:8] reply_byte
  output logic [1:0]  m_axis_tuser   // [1:0] out_kind
);

  `include "assert_macros.svh"

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  kind_e      out_kind_q;
  logic [7:0] out_byte_q;
  logic [7:0] out_reply_q;

  result_t    result;
  logic       advance;
  logic [1:0] held_count;

  efr_frame_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .byte_i      (in_byte_q),
    .result_o    (result),
    .held_count_o(held_count)
  );

  assign advance       = in_valid_q && (!result.valid || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      out_kind_q  <= result.kind;
      out_byte_q  <= result.data;
      out_reply_q <= result.reply;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_reply_q, out_byte_q};
  assign m_axis_tuser  = out_kind_q;

  `EFR_ASSERT(a_held_count_range, held_count != 2'd3, "held byte count out of range")
  `EFR_ASSERT(a_good_reply, !(m_axis_tvalid && m_axis_tuser == KIND_GOOD) || m_axis_tdata[15:8] == CH_ACK, "good packet without ACK")
  `EFR_ASSERT(a_payload_reply, !(m_axis_tvalid && (m_axis_tuser == KIND_PAYLOAD || m_axis_tuser == KIND_ABORT)) || m_axis_tdata[15:8] == 8'h00, "nonzero reply on payload or abort")
  `EFR_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q && $stable(in_byte_q), "input register lost a stalled byte")

endmodule

@@ dv/testbench.sv @@
module testbench;
  import efr_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] reply;
  } rx_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [15:8] reply_byte
  logic [1:0]  m_axis_tuser;           // [1:0] out_kind

  escaped_frame_receiver_xor_check_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  phase_e     fr_phase    = PH_AWAIT;
  logic       fr_escaped  = 1'b0;
  logic [7:0] fr_len      = 8'h00;
  logic [7:0] fr_pos      = 8'h00;
  logic [7:0] fr_xor      = 8'h00;
  logic [7:0] fr_held [2] = '{8'h00, 8'h00};
  logic [1:0] fr_held_cnt = 2'd0;

  rx_result_t awaited_results [$];
  logic [7:0] line_q [$];
  logic [7:0] line_xor;

  bit idling_on = 1'b1;
  bit hold_req  = 1'b0;
  int hold_left;
  int stall_left;
  int quiet_cycles;
  int error_count;
  int bytes_sent;
  int payload_seen;
  int good_seen;
  int bad_seen;
  int abort_seen;

  function automatic void decode_line_byte(input logic [7:0] b);
    rx_result_t r;
    if (fr_phase != PH_SIZE && fr_phase != PH_CONTENT) begin
      if (b == CH_SOH) begin
        fr_phase    = PH_SIZE;
        fr_escaped  = 1'b0;
        fr_len      = 8'h00;
        fr_pos      = 8'h00;
        fr_xor      = 8'h00;
        fr_held_cnt = 2'd0;
      end else begin
        fr_phase = PH_AWAIT;
      end
      return;
    end
    if (fr_escaped) begin
      fr_escaped = 1'b0;
    end else if (b == CH_DLE) begin
      fr_escaped = 1'b1;
      return;
    end else if (fr_phase == PH_CONTENT && fr_pos == 8'd1 && b == CH_EOT) begin
      r.kind  = (fr_xor == 8'h00) ? KIND_GOOD : KIND_BAD;
      r.data  = fr_held[0];
      r.reply = (fr_xor == 8'h00) ? CH_ACK : CH_NAK;
      awaited_results.push_back(r);
      fr_phase = PH_AWAIT;
      return;
    end else if (b == CH_SOH || b == CH_EOT) begin
      r.kind  = KIND_ABORT;
      r.data  = 8'h00;
      r.reply = 8'h00;
      awaited_results.push_back(r);
      fr_phase = PH_AWAIT;
      return;
    end
    if (fr_phase == PH_SIZE) begin
      fr_phase = PH_CONTENT;
      fr_len   = b;
      fr_pos   = 8'h00;
    end else begin
      if (fr_pos != POS_MAX) fr_pos++;
      if (fr_pos == fr_len) fr_phase = PH_SIZE;
    end
    fr_xor ^= b;
    if (fr_held_cnt >= 2'd2) begin
      r.kind  = KIND_PAYLOAD;
      r.data  = fr_held[0];
      r.reply = 8'h00;
      awaited_results.push_back(r);
      fr_held[0] = fr_held[1];
      fr_held[1] = b;
    end else begin
      fr_held[fr_held_cnt[0]] = b;
      fr_held_cnt++;
    end
  endfunction

  // Kept bytes that look like control characters go out escaped.
  function automatic void add_kept(input logic [7:0] b);
    if (b == CH_SOH || b == CH_EOT || b == CH_DLE) line_q.push_back(CH_DLE);
    line_q.push_back(b);
    line_xor ^= b;
  endfunction

  function automatic void add_packet(input int frames, input int min_len, input int max_len,
                                     input bit good);
    int len;
    line_q.push_back(CH_SOH);
    line_xor = 8'h00;
    for (int f = 0; f < frames; f++) begin
      len = $urandom_range(min_len, max_len);
      add_kept(len[7:0]);
      for (int i = 0; i < len; i++) add_kept(8'($urandom));
    end
    add_kept(8'($urandom));
    add_kept(good ? line_xor : line_xor ^ 8'($urandom_range(1, 255)));
    line_q.push_back(CH_EOT);
  endfunction

  function automatic logic [7:0] line_noise();
    case ($urandom_range(0, 5))
      0: return CH_SOH;
      1: return CH_EOT;
      2: return CH_DLE;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idling_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_line_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line();
    while (line_q.size() != 0) send_byte(line_q.pop_front());
  endtask

  // Bytes that cause no result may still be in flight when the queue empties.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic test_noise_before_start();
    line_q = '{8'h00, 8'hFF, CH_DLE};
    send_line();
  endtask

  task automatic test_good_packet();
    line_q = '{CH_SOH, 8'h03, CH_DLE, CH_SOH, CH_DLE, CH_DLE, 8'h00, 8'hFF, 8'hED, CH_EOT};
    send_line();
  endtask

  task automatic test_bad_packet();
    line_q = '{CH_SOH, 8'h01, 8'h00, 8'h00, 8'h5A, CH_EOT};
    send_line();
  endtask

  task automatic test_stray_markers();
    line_q = '{CH_SOH, 8'h03, CH_EOT, CH_SOH, CH_SOH};
    send_line();
  endtask

  task automatic test_zero_length_frame();
    line_q = '{CH_SOH, 8'h00, 8'hAA, 8'h55, CH_DLE, CH_EOT, CH_EOT};
    send_line();
  endtask

  task automatic test_random_traffic(input int target);
    int keep;
    while (bytes_sent < target) begin
      idling_on = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6)) line_q.push_back(line_noise());
        1: begin
          add_packet($urandom_range(1, 3), 1, 8, 1'b1);
          keep = $urandom_range(1, line_q.size() - 1);
          while (line_q.size() > keep) void'(line_q.pop_back());
          line_q.push_back($urandom_range(0, 1) ? CH_SOH : CH_EOT);
        end
        2: begin
          line_q.push_back(CH_SOH);
          repeat ($urandom_range(1, 12)) line_q.push_back(line_noise());
        end
        default: add_packet($urandom_range(1, 4), 1, ($urandom_range(0, 7) == 0) ? 40 : 8,
                            $urandom_range(0, 3) != 0);
      endcase
      send_line();
    end
    idling_on = 1'b1;
  endtask

  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (3) add_packet(3, 1, 8, 1'b1);
    send_line();
    drain_results();
  endtask

  task automatic test_long_frames();
    add_packet(1, 255, 255, 1'b1);
    line_q.push_back(CH_SOH);
    add_kept(8'h00);
    repeat (300) add_kept(8'($urandom));
    line_q.push_back(CH_EOT);
    send_line();
  endtask

  task automatic test_no_idling(input int count);
    int stop_at;
    stop_at   = bytes_sent + count;
    idling_on = 1'b0;
    while (bytes_sent < stop_at) begin
      add_packet($urandom_range(1, 4), 1, 8, $urandom_range(0, 3) != 0);
      send_line();
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (!idling_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 18);
    end
  end

  always @(posedge clk_i) begin
    rx_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        $error("Unexpected result beat: kind %0d, byte %02h, reply %02h",
               m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("out_kind mismatch: expected %0d, actual %0d", want.kind, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[7:0] !== want.data) begin
          $error("out_byte mismatch: expected %02h, actual %02h", want.data, m_axis_tdata[7:0]);
          error_count++;
        end
        if (m_axis_tdata[15:8] !== want.reply) begin
          $error("reply_byte mismatch: expected %02h, actual %02h",
                 want.reply, m_axis_tdata[15:8]);
          error_count++;
        end
        case (want.kind)
          KIND_PAYLOAD: payload_seen++;
          KIND_GOOD:    good_seen++;
          KIND_BAD:     bad_seen++;
          default:      abort_seen++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("No beat accepted for %0d cycles.", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_noise_before_start();
    test_good_packet();
    test_bad_packet();
    test_stray_markers();
    test_zero_length_frame();
    test_random_traffic(700);
    test_output_stall();
    test_long_frames();
    test_no_idling(250);
    drain_results();
    if (awaited_results.size() != 0) begin
      $error("%0d expected results never arrived.", awaited_results.size());
      error_count++;
    end
    $display("Sent %0d line bytes; checked %0d payload, %0d good, %0d bad and %0d aborted.",
             bytes_sent, payload_seen, good_seen, bad_seen, abort_seen);
    $display("Traffic covered noise, escapes, stray markers, long frames and output stalls.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
